### hdl/bounded_deque_defines.svh
// Assertion macros used by the checker file bdq_checker.sv.
`ifndef BOUNDED_DEQUE_DEFINES_SVH
`define BOUNDED_DEQUE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BDQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/bdq_pkg.sv
package bdq_pkg;

   localparam int DATA_W = 18;
   localparam int KIND_W = 3;
   localparam int STAT_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_DUMP       = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_PUSH_BACK  = 3'd2,
      KIND_POP_FRONT  = 3'd3,
      KIND_POP_BACK   = 3'd4,
      KIND_CLEAR      = 3'd5
   } kind_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

endpackage

### hdl/bdq_ram.sv
module bdq_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 18
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bounded_deque.sv
// Channel    Direction  Transfer                   Ports
// request    in         start & !busy              req_kind, req_value
// response   out        rsp_strobe, one cycle      rsp_data, rsp_status, rsp_last
//
// Push, pop and clear: one transaction per cycle while not busy, response in the cycle after acceptance.
// Dump: one response per stored entry (one STAT_EMPTY if none), one per cycle, busy held until the last is read.
// The single read port of the ring store sets the dump rate.
// Reset clears front pointer and occupancy; store contents are left as they are.
// Responses cannot be stalled.
module bounded_deque
   import bdq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic [STAT_W-1:0]        rsp_status,
   output logic                     rsp_last
);

   localparam int IW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
      logic [IW:0] s;
      s = {1'b0, base} + {1'b0, off};
      if (s >= (IW+1)'(DEPTH)) begin
         s = s - (IW+1)'(DEPTH);
      end
      return s[IW-1:0];
   endfunction

   state_type   state_ff, state_in;
   logic [IW-1:0] front_ff, front_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [OW-1:0] cnt_ff, cnt_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_mem_ff, rsp_mem_in;

   logic              wr_en, rd_en;
   logic [IW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              full, empty;
   logic [OW-1:0]     occ_m1;
   logic [IW-1:0]     front_dec, slot_back, slot_last;

   bdq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff == ST_DUMP);
   assign full   = (occ_ff == OW'(DEPTH));
   assign empty  = (occ_ff == '0);
   assign occ_m1 = occ_ff - OW'(1);

   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - IW'(1);
   assign slot_back = wrap_add(front_ff, occ_ff[IW-1:0]);
   assign slot_last = wrap_add(front_ff, occ_m1[IW-1:0]);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_last_in   = 1'b1;
      rsp_mem_in    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = front_dec;
      rd_en         = 1'b0;
      rd_addr       = front_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind_type'(req_kind))
                  KIND_DUMP: begin
                     rsp_strobe_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        rsp_mem_in  = 1'b1;
                        rsp_last_in = (occ_ff == OW'(1));
                        cnt_in      = OW'(1);
                        ptr_in      = wrap_add(front_ff, IW'(1));
                        if (occ_ff != OW'(1)) begin
                           state_in = ST_DUMP;
                        end
                     end
                  end
                  KIND_PUSH_FRONT: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        occ_in   = occ_ff + OW'(1);
                     end
                  end
                  KIND_PUSH_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = slot_back;
                        occ_in  = occ_ff + OW'(1);
                     end
                  end
                  KIND_POP_FRONT: begin
                     rsp_strobe_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = front_ff;
                        rsp_mem_in = 1'b1;
                        front_in   = wrap_add(front_ff, IW'(1));
                        occ_in     = occ_m1;
                     end
                  end
                  KIND_POP_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rd_en      = 1'b1;
                        rd_addr    = slot_last;
                        rsp_mem_in = 1'b1;
                        occ_in     = occ_m1;
                     end
                  end
                  KIND_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     occ_in        = '0;
                     front_in      = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DUMP: begin
            rd_en         = 1'b1;
            rd_addr       = ptr_ff;
            rsp_strobe_in = 1'b1;
            rsp_mem_in    = 1'b1;
            rsp_last_in   = (cnt_ff == occ_m1);
            cnt_in        = cnt_ff + OW'(1);
            ptr_in        = wrap_add(ptr_ff, IW'(1));
            if (cnt_ff == occ_m1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         front_ff      <= '0;
         occ_ff        <= '0;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         occ_ff        <= occ_in;
         ptr_ff        <= ptr_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_mem_ff    <= rsp_mem_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_data   = rsp_mem_ff ? rd_data : '0;

endmodule

### hdl/bdq_checker.sv
`include "bounded_deque_defines.svh"

module bdq_checker
   import bdq_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic [KIND_W-1:0]        req_kind,
   input logic                     rsp_strobe,
   input logic signed [DATA_W-1:0] rsp_data,
   input logic [STAT_W-1:0]        rsp_status,
   input logic                     rsp_last
);

   logic acc_valid_kind;
   logic acc_bad_kind;

   assign acc_valid_kind = start && !busy && (req_kind <= KIND_CLEAR);
   assign acc_bad_kind   = start && !busy && (req_kind > KIND_CLEAR);

   `BDQ_ASSERT_NEXT(a_resp_follows, clock, reset, acc_valid_kind, rsp_strobe, "no response after transaction")
   `BDQ_ASSERT_NEXT(a_bad_kind_silent, clock, reset, acc_bad_kind, !rsp_strobe, "response to unknown kind")
   `BDQ_ASSERT_NOW(a_err_resp, clock, reset, rsp_strobe && (rsp_status != STAT_OK), (rsp_data == '0) && rsp_last, "error response not zero and last")
   `BDQ_ASSERT_NEXT(a_dump_stream, clock, reset, busy, rsp_strobe, "gap in dump stream")
   `BDQ_ASSERT_NOW(a_not_last_busy, clock, reset, rsp_strobe && !rsp_last, busy, "partial dump while idle")

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_kind   (req_kind),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data),
   .rsp_status (rsp_status),
   .rsp_last   (rsp_last)
);

### tb/tb_top.sv
module tb_top;
   import bdq_pkg::*;

   localparam int DEPTH          = 32;
   localparam int RANDOM_ITEMS   = 370;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 2 * DEPTH + 8;

   localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VALUE_TOP    = 18'sh1FFFF;
   localparam logic signed [DATA_W-1:0] VALUE_BOTTOM = 18'sh20000;
   localparam logic signed [DATA_W-1:0] VALUE_HIGH   = 18'sd99999;
   localparam logic signed [DATA_W-1:0] VALUE_LOW    = -18'sd9999;

   typedef struct {
      logic [KIND_W-1:0]        kind;
      logic signed [DATA_W-1:0] value;
      int                       idle_pct;
      bit                       drain;
   } req_item_t;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic                     last;
   } rsp_item_t;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     start      = 1'b0;
   logic [KIND_W-1:0]        req_kind   = '0;
   logic signed [DATA_W-1:0] req_value  = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_data;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_last;

   req_item_t req_backlog[$];
   rsp_item_t rsp_due[$];

   // shadow deque
   logic signed [DATA_W-1:0] ring[DEPTH];
   int unsigned              head;
   int unsigned              fill;

   int n_errors   = 0;
   int n_requests = 0;
   int n_rsp      = 0;
   int n_dumps    = 0;
   int n_full     = 0;
   int n_empty    = 0;
   int n_wraps    = 0;
   int idle_count = 0;

   int cur_idle  = 0;
   bit cur_drain = 1'b0;

   bounded_deque #(.DEPTH(DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_kind   (req_kind),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag(input string what);
      n_errors++;
      $display("mismatch: %s", what);
   endtask

   task automatic deque_apply(input logic [KIND_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value);
      rsp_item_t   r;
      int unsigned k;
      r.data   = '0;
      r.status = STAT_OK;
      r.last   = 1'b1;
      case (kind)
         KIND_DUMP: begin
            n_dumps++;
            if (fill == 0) begin
               r.status = STAT_EMPTY;
               n_empty++;
               rsp_due.push_back(r);
            end else begin
               for (k = 0; k < fill; k++) begin
                  r.data = ring[(head + k) % DEPTH];
                  r.last = (k + 1 == fill);
                  rsp_due.push_back(r);
               end
            end
         end
         KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (fill >= DEPTH) begin
               r.status = STAT_FULL;
               n_full++;
            end else if (kind == KIND_PUSH_FRONT) begin
               if (head == 0) n_wraps++;
               head = (head + DEPTH - 1) % DEPTH;
               ring[head] = value;
               fill++;
            end else begin
               ring[(head + fill) % DEPTH] = value;
               fill++;
            end
            rsp_due.push_back(r);
         end
         KIND_POP_FRONT, KIND_POP_BACK: begin
            if (fill == 0) begin
               r.status = STAT_EMPTY;
               n_empty++;
            end else if (kind == KIND_POP_FRONT) begin
               r.data = ring[head];
               head = (head + 1) % DEPTH;
               fill--;
            end else begin
               r.data = ring[(head + fill - 1) % DEPTH];
               fill--;
            end
            rsp_due.push_back(r);
         end
         KIND_CLEAR: begin
            head = 0;
            fill = 0;
            rsp_due.push_back(r);
         end
         default: begin
         end
      endcase
   endtask

   task automatic add_req(input logic [KIND_W-1:0] kind,
                          input logic signed [DATA_W-1:0] value);
      req_item_t it;
      it.kind     = kind;
      it.value    = value;
      it.idle_pct = cur_idle;
      it.drain    = cur_drain;
      cur_drain   = 1'b0;
      req_backlog.push_back(it);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return DATA_W'($urandom_range(0, 109998)) + VALUE_LOW;
      if (sel < 85) return DATA_W'($urandom);
      case ($urandom_range(0, 5))
         0:       return VALUE_TOP;
         1:       return VALUE_BOTTOM;
         2:       return VALUE_HIGH;
         3:       return VALUE_LOW;
         4:       return '0;
         default: return -18'sd1;
      endcase
   endfunction

   function automatic logic [KIND_W-1:0] pick_push();
      return ($urandom_range(0, 1) != 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
   endfunction

   function automatic logic [KIND_W-1:0] pick_pop();
      return ($urandom_range(0, 1) != 0) ? KIND_POP_FRONT : KIND_POP_BACK;
   endfunction

   function automatic logic [KIND_W-1:0] pick_any();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 46) return pick_push();
      if (sel < 84) return pick_pop();
      if (sel < 93) return KIND_DUMP;
      if (sel < 97) return KIND_CLEAR;
      return ($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
   endfunction

   task automatic build_stimulus();
      int made;
      int base;
      int phase;
      int last_phase;
      int n;
      int k;
      int idle_by_phase[4];
      idle_by_phase = '{0, 53, 0, 33};

      // empty-queue refusals and spare codes
      add_req(KIND_POP_FRONT, VALUE_TOP);
      add_req(KIND_POP_BACK, VALUE_BOTTOM);
      add_req(KIND_DUMP, '0);
      add_req(KIND_SPARE_6, VALUE_TOP);
      add_req(KIND_SPARE_7, VALUE_BOTTOM);
      // out-of-range and range-edge values, front push wraps the index
      add_req(KIND_PUSH_BACK, VALUE_TOP);
      add_req(KIND_PUSH_FRONT, VALUE_BOTTOM);
      add_req(KIND_PUSH_BACK, VALUE_HIGH);
      add_req(KIND_PUSH_FRONT, VALUE_LOW);
      add_req(KIND_PUSH_BACK, '0);
      add_req(KIND_PUSH_FRONT, -18'sd1);
      add_req(KIND_DUMP, VALUE_TOP);
      add_req(KIND_POP_FRONT, '0);
      add_req(KIND_POP_BACK, '0);
      add_req(KIND_DUMP, '0);
      add_req(KIND_CLEAR, VALUE_TOP);
      add_req(KIND_DUMP, '0);
      add_req(KIND_POP_BACK, '0);
      add_req(KIND_PUSH_FRONT, 18'sd123);
      add_req(KIND_POP_BACK, '0);
      add_req(KIND_PUSH_BACK, 18'sd5);
      add_req(KIND_DUMP, '0);
      add_req(KIND_CLEAR, '0);

      base       = req_backlog.size();
      made       = 0;
      last_phase = -1;
      while (made < RANDOM_ITEMS) begin
         phase = (made * 4) / RANDOM_ITEMS;
         if (phase != last_phase) begin
            cur_idle   = idle_by_phase[phase];
            cur_drain  = 1'b1;
            last_phase = phase;
         end
         if ($urandom_range(0, 2) == 0) begin
            // clear, push DEPTH-2 to DEPTH+4 times, dump, then pop (one in ten a dump) up to DEPTH+4 times
            add_req(KIND_CLEAR, pick_value());
            n = $urandom_range(DEPTH - 2, DEPTH + 4);
            for (k = 0; k < n; k++) add_req(pick_push(), pick_value());
            add_req(KIND_DUMP, pick_value());
            n = $urandom_range(0, DEPTH + 4);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 9) == 0) add_req(KIND_DUMP, pick_value());
               else add_req(pick_pop(), pick_value());
            end
            made = req_backlog.size() - base;
         end else begin
            n = $urandom_range(8, 30);
            for (k = 0; k < n; k++) add_req(pick_any(), pick_value());
            made += n;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      req_item_t nxt;
      bit        fire;
      bit        go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         fire = start && !busy;
         if (fire) begin
            n_requests++;
            deque_apply(req_kind, req_value);
         end
         if (fire || !start) begin
            go = 1'b0;
            if (req_backlog.size() != 0) begin
               nxt = req_backlog[0];
               if (nxt.drain && rsp_due.size() != 0) go = 1'b0;
               else if ($urandom_range(0, 99) < nxt.idle_pct) go = 1'b0;
               else go = 1'b1;
            end
            if (go) begin
               void'(req_backlog.pop_front());
               start     <= 1'b1;
               req_kind  <= nxt.kind;
               req_value <= nxt.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_t want;
      if (!reset && rsp_strobe) begin
         n_rsp++;
         if (rsp_due.size() == 0) begin
            flag($sformatf("unexpected response data %0d status %0d last %0b",
                           rsp_data, rsp_status, rsp_last));
         end else begin
            want = rsp_due.pop_front();
            if (rsp_data !== want.data)
               flag($sformatf("response %0d data %0d, expected %0d", n_rsp, rsp_data,
                              want.data));
            if (rsp_status !== want.status)
               flag($sformatf("response %0d status %0d, expected %0d", n_rsp, rsp_status,
                              want.status));
            if (rsp_last !== want.last)
               flag($sformatf("response %0d last %0b, expected %0b", n_rsp, rsp_last,
                              want.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("timeout: %0d responses still due", rsp_due.size());
         $display("tb: failure");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      head = 0;
      fill = 0;
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (req_backlog.size() != 0 || start) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("summary: %0d requests, %0d responses, %0d dumps, %0d front wraps",
               n_requests, n_rsp, n_dumps, n_wraps);
      $display("summary: %0d full refusals, %0d empty refusals, %0d mismatches",
               n_full, n_empty, n_errors);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
